### rtl/bbra_pkg.sv
// shared types, constants and helpers of the block run allocator
package bbra_pkg;

  localparam int BLOCKS      = 64;
  localparam int BLK_W       = 6;
  localparam int ADDR_W      = 18;
  localparam int SIZE_W      = 12;
  localparam int PAGE_FLD_W  = 6;
  localparam logic [6:0] MAX_RUN = 7'd63;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_PAGE      = 2'd1,
    ST_UNKNOWN_PAGE = 2'd2
  } status_t;

  // classified command handed from front to back
  typedef struct packed {
    logic                  is_free;
    logic                  too_big;
    logic [BLK_W-1:0]      blocks;
    logic [PAGE_FLD_W-1:0] page;
    logic [BLK_W-1:0]      blk;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_OPEN,
    BK_FREE_UPD,
    BK_DONE
  } bk_state_t;

  // low len bits set
  function automatic logic [BLOCKS-1:0] run_mask(input logic [BLK_W-1:0] len);
    run_mask = (64'd1 << len) - 64'd1;
  endfunction

endpackage

### rtl/bbra_ifs.sv
// valid/ready channel interfaces for requests and results
interface bbra_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [11:0] size_bytes;
  logic [17:0] free_address;
  modport source (output valid, opcode, size_bytes, free_address, input ready);
  modport sink   (input valid, opcode, size_bytes, free_address, output ready);
endinterface

interface bbra_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] result_address;
  logic [1:0]  status;
  modport source (output valid, result_address, status, input ready);
  modport sink   (input valid, result_address, status, output ready);
endinterface

### rtl/bbra_front.sv
// request intake, classification and two-entry command queue
module bbra_front (
  input  logic              clk,
  input  logic              rst_n,
  bbra_in_if.sink           in_ch,
  output bbra_pkg::cmd_t    q_cmd,
  output logic              q_valid,
  input  logic              q_pop
);

  bbra_pkg::cmd_t q_r [2];
  bbra_pkg::cmd_t cmd_in;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic [6:0]     blocks_raw;
  logic           push, pop;

  // round bytes up to blocks, zero size takes one block
  always_comb begin
    blocks_raw       = 7'(({1'b0, in_ch.size_bytes} + 13'd63) >> 6);
    cmd_in.is_free   = (in_ch.opcode == bbra_pkg::OP_FREE);
    cmd_in.too_big   = (blocks_raw > bbra_pkg::MAX_RUN);
    cmd_in.blocks    = (blocks_raw == 7'd0) ? 6'd1 : blocks_raw[5:0];
    cmd_in.page      = in_ch.free_address[17:12];
    cmd_in.blk       = in_ch.free_address[11:6];
  end

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != 2'd0);
  assign pop         = q_pop && q_valid;
  assign q_cmd       = q_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("command queue overfilled");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers out of step");

endmodule

### rtl/bbra_back.sv
// allocation engine: page scan, page open sweep, free, result register
module bbra_back #(
  parameter int PAGES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bbra_pkg::cmd_t    q_cmd,
  input  logic              q_valid,
  output logic              q_pop,
  bbra_out_if.source        out_ch
);

  localparam int PW   = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int OW   = $clog2(PAGES + 1);
  localparam int CMPW = (OW > 6) ? OW : 6;
  localparam int LW   = PW + bbra_pkg::BLK_W;

  bbra_pkg::bk_state_t state_r, state_nxt;
  bbra_pkg::cmd_t      cmd_r, cmd_nxt;
  logic [OW-1:0]       page_r, page_nxt;
  logic [OW-1:0]       pages_open_r, pages_open_nxt;
  logic [5:0]          clr_r, clr_nxt;
  logic [17:0]         res_addr_r, res_addr_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [17:0]         out_addr_r, out_addr_nxt;
  logic [1:0]          out_status_r, out_status_nxt;

  // memories
  logic [63:0]         bm_mem [PAGES];
  logic [5:0]          len_mem [PAGES*64];
  logic [63:0]         bm_rd_r;
  logic [5:0]          len_rd_r;
  logic [PW-1:0]       bm_raddr, bm_waddr;
  logic [LW-1:0]       len_raddr, len_waddr;
  logic                bm_we, len_we;
  logic [63:0]         bm_wdata;
  logic [5:0]          len_wdata;

  // run search over one page
  logic [63:0]         fit;
  logic [5:0]          start;
  logic                found;
  logic [63:0]         mask;
  logic [PW-1:0]       new_idx;
  logic                free_known;

  assign mask    = bbra_pkg::run_mask(cmd_r.blocks);
  assign new_idx = PW'(pages_open_r);

  always_comb begin
    fit   = '0;
    start = '0;
    for (int i = 1; i < 64; i++) begin
      fit[i] = ((7'(i) + {1'b0, cmd_r.blocks}) <= 7'd64) &&
               (((bm_rd_r >> i) & mask) == 64'd0);
    end
    for (int i = 63; i >= 1; i--) begin
      if (fit[i]) begin
        start = 6'(i);
      end
    end
    found = |fit;
  end

  assign free_known = CMPW'(q_cmd.page) < CMPW'(pages_open_r);

  // control and next state
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    page_nxt       = page_r;
    pages_open_nxt = pages_open_r;
    clr_nxt        = clr_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    q_pop          = 1'b0;
    bm_raddr       = PW'(page_r);
    len_raddr      = {PW'(q_cmd.page), q_cmd.blk};
    bm_we          = 1'b0;
    bm_waddr       = PW'(page_r);
    bm_wdata       = bm_rd_r | (mask << start);
    len_we         = 1'b0;
    len_waddr      = {PW'(page_r), start};
    len_wdata      = cmd_r.blocks;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      bbra_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop          = 1'b1;
          cmd_nxt        = q_cmd;
          res_addr_nxt   = '0;
          res_status_nxt = bbra_pkg::ST_OK;
          page_nxt       = '0;
          clr_nxt        = '0;
          if (q_cmd.is_free) begin
            bm_raddr = PW'(q_cmd.page);
            if (free_known) begin
              state_nxt = bbra_pkg::BK_FREE_UPD;
            end else begin
              res_status_nxt = bbra_pkg::ST_UNKNOWN_PAGE;
              state_nxt      = bbra_pkg::BK_DONE;
            end
          end else if (q_cmd.too_big) begin
            res_status_nxt = bbra_pkg::ST_NO_PAGE;
            state_nxt      = bbra_pkg::BK_DONE;
          end else if (pages_open_r == '0) begin
            state_nxt = bbra_pkg::BK_OPEN;
          end else begin
            bm_raddr  = '0;
            state_nxt = bbra_pkg::BK_SCAN;
          end
        end
      end
      bbra_pkg::BK_SCAN: begin
        bm_raddr = PW'(page_r + OW'(1));
        if (found) begin
          bm_we        = 1'b1;
          len_we       = 1'b1;
          res_addr_nxt = {6'(page_r), start, 6'd0};
          state_nxt    = bbra_pkg::BK_DONE;
        end else if (page_r + OW'(1) < pages_open_r) begin
          page_nxt = page_r + OW'(1);
        end else if (pages_open_r == OW'(PAGES)) begin
          res_status_nxt = bbra_pkg::ST_NO_PAGE;
          state_nxt      = bbra_pkg::BK_DONE;
        end else begin
          state_nxt = bbra_pkg::BK_OPEN;
        end
      end
      bbra_pkg::BK_OPEN: begin
        // zero the new page's lengths, the first run lands at block one
        len_we    = 1'b1;
        len_waddr = {new_idx, clr_r};
        len_wdata = (clr_r == 6'd1) ? cmd_r.blocks : 6'd0;
        clr_nxt   = clr_r + 6'd1;
        if (clr_r == 6'd63) begin
          bm_we          = 1'b1;
          bm_waddr       = new_idx;
          bm_wdata       = 64'd1 | (mask << 1);
          pages_open_nxt = pages_open_r + OW'(1);
          res_addr_nxt   = {6'(pages_open_r), 6'd1, 6'd0};
          state_nxt      = bbra_pkg::BK_DONE;
        end
      end
      bbra_pkg::BK_FREE_UPD: begin
        bm_we     = 1'b1;
        bm_waddr  = PW'(cmd_r.page);
        bm_wdata  = (bm_rd_r & ~(bbra_pkg::run_mask(len_rd_r) << cmd_r.blk)) | 64'd1;
        state_nxt = bbra_pkg::BK_DONE;
      end
      bbra_pkg::BK_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = bbra_pkg::BK_IDLE;
        end
      end
      default: state_nxt = bbra_pkg::BK_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bbra_pkg::BK_IDLE;
      pages_open_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pages_open_r <= pages_open_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    page_r       <= page_nxt;
    clr_r        <= clr_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  // page bitmaps
  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    bm_rd_r <= bm_mem[bm_raddr];
  end

  // run lengths
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_waddr] <= len_wdata;
    end
    len_rd_r <= len_mem[len_raddr];
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_address = out_addr_r;
  assign out_ch.status         = out_status_r;

  a_open_max: assert property (@(posedge clk) disable iff (!rst_n)
    pages_open_r <= OW'(PAGES))
    else $error("more pages open than exist");
  a_open_step: assert property (@(posedge clk) disable iff (!rst_n)
    (pages_open_r != pages_open_nxt) |-> pages_open_nxt == pages_open_r + OW'(1))
    else $error("page count jumped");
  a_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    bm_we |-> bm_wdata[0])
    else $error("reserved block cleared");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == bbra_pkg::BK_IDLE)
    else $error("command taken while busy");

endmodule

### rtl/bitmap_block_run_allocator_core.sv
// top level of the bitmap block run allocator
// a free of an opened page updates its bitmap from the stored run length; a free of an
// unopened page or an oversized allocate goes straight to the result; an allocate scans
// the opened pages and opens a new page when none fits, sweeping its 64 run lengths; the
// back engine holds one item and takes the next only once its result is registered
// reset: synchronous active low, clears queue, page count and output valid
module bitmap_block_run_allocator_core #(
  parameter int PAGES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  bbra_in_if.sink     in_ch,
  bbra_out_if.source  out_ch
);

  bbra_pkg::cmd_t q_cmd;
  logic           q_valid;
  logic           q_pop;

  bbra_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  bbra_back #(.PAGES(PAGES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_cmd   (q_cmd),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule
